@@ rtl/core/qah_pkg.sv @@
// ----------------------------------------------------------------------------
// qah_pkg
// Shared types and constants for the quadrilateral area unit.
// ----------------------------------------------------------------------------
package qah_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned SumW   = ProdW - 1;
  localparam int unsigned AreaW  = 24;
  // area_q8 = 128 * (|cross1| + |cross2|)
  localparam int unsigned AreaShift = 7;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic [AreaW-1:0] area_t;

  // Four cross-product terms, two per triangle
  typedef struct packed {
    prod_t t1_a;
    prod_t t1_b;
    prod_t t2_a;
    prod_t t2_b;
  } terms_t;

endpackage

@@ rtl/core/qah_if.sv @@
// ----------------------------------------------------------------------------
// qah_in_if / qah_out_if
// Valid/ready channels for quadrilateral vertices and the resulting area.
// ----------------------------------------------------------------------------
interface qah_in_if;
  logic            valid;
  logic            ready;
  qah_pkg::coord_t vertex0_x;
  qah_pkg::coord_t vertex0_y;
  qah_pkg::coord_t vertex1_x;
  qah_pkg::coord_t vertex1_y;
  qah_pkg::coord_t vertex2_x;
  qah_pkg::coord_t vertex2_y;
  qah_pkg::coord_t vertex3_x;
  qah_pkg::coord_t vertex3_y;

  modport source (output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                  vertex2_x, vertex2_y, vertex3_x, vertex3_y, input ready);
  modport sink   (input valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                  vertex2_x, vertex2_y, vertex3_x, vertex3_y, output ready);
endinterface

interface qah_out_if;
  logic           valid;
  logic           ready;
  qah_pkg::area_t area_q8;

  modport source (output valid, area_q8, input ready);
  modport sink   (input valid, area_q8, output ready);
endinterface

@@ rtl/core/qah_front.sv @@
// ----------------------------------------------------------------------------
// qah_front
// Takes vertices, forms edge vectors and registers the cross-product terms.
// ----------------------------------------------------------------------------
module qah_front (
  input  logic             clk,
  input  logic             rst_n,
  qah_in_if.sink           in_ch,
  output logic             q_valid,
  input  logic             q_ready,
  output qah_pkg::terms_t  q_terms
);

  logic            valid_r, valid_nxt;
  qah_pkg::terms_t terms_r, terms_nxt;
  logic            take;
  qah_pkg::diff_t  ux1, uy1, vx1, vy1, ux2, uy2, vx2, vy2;

  function automatic qah_pkg::diff_t sub(input qah_pkg::coord_t a, input qah_pkg::coord_t b);
    sub = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  assign in_ch.ready = !valid_r || q_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    // triangle v0,v1,v2 about v0; triangle v2,v3,v0 about v2
    ux1 = sub(in_ch.vertex1_x, in_ch.vertex0_x);
    uy1 = sub(in_ch.vertex1_y, in_ch.vertex0_y);
    vx1 = sub(in_ch.vertex2_x, in_ch.vertex0_x);
    vy1 = sub(in_ch.vertex2_y, in_ch.vertex0_y);
    ux2 = sub(in_ch.vertex3_x, in_ch.vertex2_x);
    uy2 = sub(in_ch.vertex3_y, in_ch.vertex2_y);
    vx2 = sub(in_ch.vertex0_x, in_ch.vertex2_x);
    vy2 = sub(in_ch.vertex0_y, in_ch.vertex2_y);
    terms_nxt.t1_a = ux1 * vy1;
    terms_nxt.t1_b = uy1 * vx1;
    terms_nxt.t2_a = ux2 * vy2;
    terms_nxt.t2_b = uy2 * vx2;
    valid_nxt = take || (valid_r && !q_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      terms_r <= terms_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_terms = terms_r;

endmodule

@@ rtl/core/qah_fifo.sv @@
// ----------------------------------------------------------------------------
// qah_fifo
// Small queue of cross-product terms between front and back.
// ----------------------------------------------------------------------------
module qah_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  qah_pkg::terms_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output qah_pkg::terms_t pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  qah_pkg::terms_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != CntW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH)) else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

@@ rtl/core/qah_back.sv @@
// ----------------------------------------------------------------------------
// qah_back
// Combines cross-product terms into the Q.8 area and holds the result.
// ----------------------------------------------------------------------------
module qah_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  qah_pkg::terms_t q_terms,
  qah_out_if.source       out_ch
);

  logic                          valid_r, valid_nxt;
  qah_pkg::area_t                area_r, area_nxt;
  qah_pkg::prod_t                c1, c2;
  logic [qah_pkg::SumW-1:0]      m1, m2;
  logic [qah_pkg::SumW:0]        sum;

  assign q_ready = !valid_r || out_ch.ready;

  always_comb begin
    c1  = q_terms.t1_a - q_terms.t1_b;
    c2  = q_terms.t2_a - q_terms.t2_b;
    m1  = c1[qah_pkg::ProdW-1] ? qah_pkg::SumW'(-c1) : qah_pkg::SumW'(c1);
    m2  = c2[qah_pkg::ProdW-1] ? qah_pkg::SumW'(-c2) : qah_pkg::SumW'(c2);
    sum = {1'b0, m1} + {1'b0, m2};
    area_nxt  = qah_pkg::AreaW'(sum) << qah_pkg::AreaShift;
    valid_nxt = (q_valid && q_ready) || (valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      area_r <= area_nxt;
    end
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.area_q8 = area_r;

endmodule

@@ rtl/core/quadrilateral_area_heron_top.sv @@
// ----------------------------------------------------------------------------
// quadrilateral_area_heron_top
// Quadrilateral area from four vertices, Heron split along diagonal v0-v2.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer carries four vertices (unsigned 8-bit x/y each).
//   out_ch : one transfer per input carries area_q8, unsigned Q.8 area.
//   Heron's 16*area^2 for integer vertices is exactly (2*cross)^2, so each
//   triangle's root is 512*|cross| and area_q8 = 128*(|cross1| + |cross2|),
//   bit-exact to the root-based form, with no root unit needed.
// Path: the front register is loaded at the input transfer, the queue is
//   written from the front register, and the output register is loaded from
//   the queue; a stall can hold an item at each of these registers.
// Throughput: one quad per cycle while out_ch does not stall; set by the single front multiply stage.
// Stall: a stalled out_ch fills the output register, then the queue of
//   QUEUE_DEPTH entries, then the front register; only then does in_ch.ready
//   drop. Results leave in input order.
// Reset: rst_n low clears all valid flags and queue pointers; the data
//   registers and queue storage are not reset.
// ----------------------------------------------------------------------------
module quadrilateral_area_heron_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  qah_in_if.sink    in_ch,
  qah_out_if.source out_ch
);

  // front -> queue
  logic            f_valid, f_ready;
  qah_pkg::terms_t f_terms;
  // queue -> back
  logic            b_valid, b_ready;
  qah_pkg::terms_t b_terms;

  // Front: edge vectors and the four products, one register stage
  qah_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_terms (f_terms)
  );

  // Queue decouples front and back stalls
  qah_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_terms),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_terms)
  );

  // Back: subtract, absolute value, sum and scale into output register
  qah_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_terms (b_terms),
    .out_ch  (out_ch)
  );

endmodule

@@ tb/tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_if
// Testbench geometry types: one quadrilateral as eight coordinates.
// ----------------------------------------------------------------------------
package tb_geom_pkg;
  typedef struct {
    logic [7:0] x0, y0, x1, y1, x2, y2, x3, y3;
  } quad_t;
endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the quadrilateral area unit against an in-bench Heron predictor.
// Directed corner quads, then random quads (mostly small, some full range),
// with random idling on both channels and one full drain mid-run.
// ----------------------------------------------------------------------------
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qah_in_if  in_ch ();
  qah_out_if out_ch ();

  quadrilateral_area_heron_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  qah_pkg::area_t area_fifo[$];
  int    n_errors = 0;
  int    n_areas  = 0;
  int    n_quads  = 0;

  // floor square root, bit by bit
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint dist_sq(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  // 16 * area^2, clamped at zero
  function automatic longint unsigned heron_t(longint a, longint b, longint c);
    longint s, t;
    s = a + b - c;
    t = 4 * a * b - s * s;
    return (t > 0) ? unsigned'(t) : 64'd0;
  endfunction

  function automatic qah_pkg::area_t quad_area(tb_geom_pkg::quad_t q);
    longint d;
    longint unsigned r;
    d = dist_sq(q.x0, q.y0, q.x2, q.y2);
    r = (floor_root(heron_t(dist_sq(q.x0, q.y0, q.x1, q.y1),
                            dist_sq(q.x1, q.y1, q.x2, q.y2), d) << 16) +
         floor_root(heron_t(dist_sq(q.x2, q.y2, q.x3, q.y3),
                            dist_sq(q.x3, q.y3, q.x0, q.y0), d) << 16)) >> 2;
    if (r > 64'hFFFFFF) r = 64'hFFFFFF;
    return qah_pkg::area_t'(r);
  endfunction

  initial begin
    in_ch.valid <= 1'b0;
    {in_ch.vertex0_x, in_ch.vertex0_y, in_ch.vertex1_x, in_ch.vertex1_y} <= '0;
    {in_ch.vertex2_x, in_ch.vertex2_y, in_ch.vertex3_x, in_ch.vertex3_y} <= '0;
    out_ch.ready <= 1'b0;
  end

  // One quad per call; idles for a drawn gap first unless no_gap is set, then holds until the
  // transfer. valid stays high after the transfer so that back-to-back
  // items follow with no gap; idle_input drops it.
  task automatic send_quad(tb_geom_pkg::quad_t q, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.vertex0_x <= q.x0; in_ch.vertex0_y <= q.y0;
    in_ch.vertex1_x <= q.x1; in_ch.vertex1_y <= q.y1;
    in_ch.vertex2_x <= q.x2; in_ch.vertex2_y <= q.y2;
    in_ch.vertex3_x <= q.x3; in_ch.vertex3_y <= q.y3;
    do @(posedge clk); while (!in_ch.ready);
    area_fifo.push_back(quad_area(q));
    n_quads++;
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  function automatic tb_geom_pkg::quad_t mk(int a, int b, int c, int d,
                                            int e, int f, int g, int h);
    tb_geom_pkg::quad_t q;
    q.x0 = 8'(a); q.y0 = 8'(b); q.x1 = 8'(c); q.y1 = 8'(d);
    q.x2 = 8'(e); q.y2 = 8'(f); q.x3 = 8'(g); q.y3 = 8'(h);
    return q;
  endfunction

  function automatic tb_geom_pkg::quad_t rand_quad(int hi);
    return mk($urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi),
              $urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi),
              $urandom_range(0, hi), $urandom_range(0, hi));
  endfunction

  // Result side: random stall before each result, checked against the oldest.
  initial begin : area_check
    qah_pkg::area_t exp_area;
    int    stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (area_fifo.size() == 0) begin
        $display("%0t: unexpected area transfer, actual %0d", $time, out_ch.area_q8);
        n_errors++;
      end else begin
        exp_area = area_fifo.pop_front();
        if (out_ch.area_q8 !== exp_area) begin
          $display("%0t: area_q8 mismatch, expected %0d actual %0d",
                   $time, exp_area, out_ch.area_q8);
          n_errors++;
        end
      end
      n_areas++;
    end
  end

  task automatic test_corners();
    send_quad(mk(0, 0, 0, 0, 0, 0, 0, 0));                 // all points coincide
    send_quad(mk(0, 0, 255, 0, 255, 255, 0, 255));         // full square, max area
    send_quad(mk(255, 255, 0, 255, 0, 0, 255, 0));
    send_quad(mk(255, 255, 255, 255, 255, 255, 255, 255));
    send_quad(mk(0, 0, 128, 128, 255, 255, 5, 200));       // first triangle flat
    send_quad(mk(0, 0, 255, 0, 128, 0, 64, 0));            // both flat
    send_quad(mk(0, 0, 255, 255, 0, 255, 255, 0));         // self-crossing
    send_quad(mk(0, 0, 200, 100, 100, 100, 100, 255));     // non-convex
    send_quad(mk(10, 10, 200, 30, 10, 10, 40, 250));       // v0 equals v2
    send_quad(mk(170, 85, 85, 170, 170, 85, 85, 170));     // alternating bits
    send_quad(mk(85, 170, 170, 85, 85, 170, 170, 85));
    send_quad(mk(0, 255, 255, 0, 0, 255, 255, 0));
    send_quad(mk(1, 2, 3, 5, 7, 11, 13, 17));
  endtask

  task automatic test_random(int count, bit burst);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) send_quad(rand_quad(255), burst);
      else                           send_quad(rand_quad($urandom_range(1, 31)), burst);
    end
  endtask

  // Sender holds off until every result is back, then resumes.
  task automatic test_drain();
    idle_input();
    while (area_fifo.size() != 0) @(posedge clk);
    test_random(100, 0);
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random(700, 0);
    test_drain();
    test_random(400, 1);                                    // back-to-back stretch
    test_random(600, 0);
    idle_input();
    waited = 0;
    while (area_fifo.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    $display("Covered %0d quads (corners, flat, crossing, full range) and %0d areas.",
             n_quads, n_areas);
    if (n_errors == 0 && area_fifo.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule
